>>> rtl/cpr_pkg.sv
// Shared types, constants and elaboration-time table functions for the
// celestial pole rotation core. Depends on nothing.
package cpr_pkg;

	localparam int WORD_W         = 64;
	localparam int WFRAC          = 58;
	localparam int STEPS          = 58;
	localparam int ANGLE_BITS_DEF = 32;
	localparam int TRIG_FRAC_DEF  = 30;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic        [WORD_W-1:0] turn_t;

	localparam word_t ONE_Q        = word_t'(64'd1 << WFRAC);
	localparam turn_t HALF_TURN    = 64'h8000_0000_0000_0000;
	localparam turn_t QUARTER_TURN = 64'h4000_0000_0000_0000;

	function automatic logic [63:0] long_div(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q;
		logic [64:0] r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[63:0], n[i]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [63:0] frac_div(input logic [63:0] num, input logic [63:0] den,
		input int bits);
		logic [63:0] n;
		logic [63:0] q;
		n = num;
		q = '0;
		for (int k = 0; k < bits; k++) begin
			n = n << 1;
			q = q << 1;
			if (n >= den) begin
				n = n - den;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [63:0] atan_inv(input logic [63:0] n);
		logic [63:0] p;
		logic [63:0] acc;
		logic [63:0] t;
		logic [63:0] k;
		p = long_div(64'd1 << 62, n);
		acc = '0;
		k = '0;
		for (int it = 0; it < 64; it++) begin
			if (p != 64'd0) begin
				t = long_div(p, (k << 1) + 64'd1);
				if (k[0]) acc = acc - t;
				else acc = acc + t;
				p = long_div(p, n * n);
				k = k + 64'd1;
			end
		end
		return acc;
	endfunction

	function automatic logic [63:0] atan_pow2(input int i);
		logic [63:0] p;
		logic [63:0] acc;
		logic [63:0] t;
		logic [63:0] k;
		p = (64'd1 << 62) >> i;
		acc = '0;
		k = '0;
		for (int it = 0; it < 64; it++) begin
			if (p != 64'd0) begin
				t = long_div(p, (k << 1) + 64'd1);
				if (k[0]) acc = acc - t;
				else acc = acc + t;
				p = (2 * i < 64) ? (p >> (2 * i)) : 64'd0;
				k = k + 64'd1;
			end
		end
		return acc;
	endfunction

	localparam logic [63:0] QUARTER_ARC = (atan_inv(64'd5) << 2) - atan_inv(64'd239);

	function automatic turn_t step_angle(input int i);
		if (i == 0) return 64'd1 << 61;
		return frac_div(atan_pow2(i), QUARTER_ARC, 61);
	endfunction

	function automatic word_t make_inv_gain();
		word_t x;
		word_t y;
		word_t dx;
		word_t dy;
		turn_t z;
		x = ONE_Q;
		y = '0;
		z = '0;
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (!z[63]) begin
				x = x - dx;
				y = y + dy;
				z = z - step_angle(i);
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + step_angle(i);
			end
		end
		return word_t'(frac_div(ONE_Q, x, WFRAC));
	endfunction

	localparam word_t INV_GAIN = make_inv_gain();

endpackage

>>> rtl/cpr_cordic_cell.sv
// One CORDIC micro-rotation cell, rotation or vectoring mode, one register.
// Depends on cpr_pkg for the word types and the arc table.
module cpr_cordic_cell #(
	parameter int STEP      = 0,
	parameter bit VECTORING = 1'b0
) (
	input  logic           clk,
	input  logic           en,
	input  cpr_pkg::word_t x,
	input  cpr_pkg::word_t y,
	input  cpr_pkg::turn_t z,
	output cpr_pkg::word_t x_q,
	output cpr_pkg::word_t y_q,
	output cpr_pkg::turn_t z_q
);
	import cpr_pkg::*;

	localparam turn_t ARC = step_angle(STEP);

	word_t dx;
	word_t dy;
	logic  up;

	always_comb begin
		dx = y >>> STEP;
		dy = x >>> STEP;
		up = VECTORING ? y[WORD_W-1] : !z[WORD_W-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (up) begin
				x_q <= x - dx;
				y_q <= y + dy;
				z_q <= z - ARC;
			end else begin
				x_q <= x + dx;
				y_q <= y - dy;
				z_q <= z + ARC;
			end
		end
	end

endmodule

>>> rtl/cpr_sqrt_cell.sv
// One digit of the bitwise square root, one register per cell.
// Depends on cpr_pkg for the word types and the fraction width.
module cpr_sqrt_cell #(
	parameter int K = 0
) (
	input  logic           clk,
	input  logic           en,
	input  cpr_pkg::turn_t u,
	input  cpr_pkg::turn_t rem,
	input  cpr_pkg::turn_t root,
	output cpr_pkg::turn_t u_q,
	output cpr_pkg::turn_t rem_q,
	output cpr_pkg::turn_t root_q
);
	import cpr_pkg::*;

	localparam bit USE_PAIR = (2 * K >= WFRAC);
	localparam int PSH      = USE_PAIR ? (2 * K - WFRAC) : 0;

	logic [1:0] pair;
	turn_t      rem_n;
	turn_t      trial;

	always_comb begin
		pair  = USE_PAIR ? 2'(u >> PSH) : 2'b00;
		rem_n = {rem[WORD_W-3:0], pair};
		trial = {root[WORD_W-3:0], 2'b01};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_q <= u;
			if (rem_n >= trial) begin
				rem_q  <= rem_n - trial;
				root_q <= {root[WORD_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_n;
				root_q <= {root[WORD_W-2:0], 1'b0};
			end
		end
	end

endmodule

>>> rtl/cpr_mul.sv
// Signed fixed-point multiply truncated toward zero, four register stages.
// Depends on cpr_pkg for the word type and the fraction width.
module cpr_mul (
	input  logic           clk,
	input  logic           en,
	input  cpr_pkg::word_t a,
	input  cpr_pkg::word_t b,
	output cpr_pkg::word_t p_q
);
	import cpr_pkg::*;

	logic         neg_s1;
	logic [63:0]  ua_s1;
	logic [63:0]  ub_s1;
	logic         neg_s2;
	logic [63:0]  pp00_s2;
	logic [63:0]  pp01_s2;
	logic [63:0]  pp10_s2;
	logic [63:0]  pp11_s2;
	logic         neg_s3;
	logic [62:0]  r_s3;
	logic [127:0] full;

	always_comb begin
		full = {64'd0, pp00_s2} + ({64'd0, pp01_s2} << 32) + ({64'd0, pp10_s2} << 32)
			+ {pp11_s2, 64'd0};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1  <= a[63] ^ b[63];
			ua_s1   <= a[63] ? 64'(-a) : 64'(a);
			ub_s1   <= b[63] ? 64'(-b) : 64'(b);
			neg_s2  <= neg_s1;
			pp00_s2 <= ua_s1[31:0] * ub_s1[31:0];
			pp01_s2 <= ua_s1[31:0] * ub_s1[63:32];
			pp10_s2 <= ua_s1[63:32] * ub_s1[31:0];
			pp11_s2 <= ua_s1[63:32] * ub_s1[63:32];
			neg_s3  <= neg_s2;
			r_s3    <= full[WFRAC+62:WFRAC];
			p_q     <= neg_s3 ? -word_t'({1'b0, r_s3}) : word_t'({1'b0, r_s3});
		end
	end

endmodule

>>> rtl/cpr_delay.sv
// Enabled shift line that keeps operands aligned with the arithmetic stages.
// Depends on nothing.
module cpr_delay #(
	parameter int W     = 1,
	parameter int DEPTH = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);
	logic [W-1:0] line_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			line_q[0] <= d;
			for (int i = 1; i < DEPTH; i++) line_q[i] <= line_q[i-1];
		end
	end

	assign q = line_q[DEPTH-1];

endmodule

>>> rtl/celestial_pole_rotation_core.sv
// Celestial pole rotation core: pipelined chains of CORDIC, multiply and square root cells.
// Depends on cpr_pkg, cpr_cordic_cell, cpr_sqrt_cell, cpr_mul and cpr_delay.
//
// Usage: load pole longitude, longitude offset and the pole latitude cosine and
// sine over the APB port while the core is idle; reads return the stored values.
// Input words (func, in_longitude, in_latitude) enter on in_valid/in_ready, one
// per cycle. Each yields one output word (out_longitude, out_latitude) on
// out_valid/out_ready. From acceptance to out_valid a word passes through
// one entry stage, 58 sine/cosine cells, a sign register, three chained
// four-stage multipliers with two adder registers between them, a 59-cell
// square root, a setup register and 58 arctangent cells, then the output register.
// Throughput is one word per cycle. The output register decouples the sides:
// while a result waits, the pipeline keeps moving until its last stage is full,
// and then holds every stage until out_ready. Reset clears all valid flags and
// loads the registers with pole longitude 0, offset 0, cosine 1.0 and sine 0.
module celestial_pole_rotation_core #(
	parameter  int ANGLE_BITS     = cpr_pkg::ANGLE_BITS_DEF,
	parameter  int TRIG_FRAC_BITS = cpr_pkg::TRIG_FRAC_DEF,
	localparam int DATA_W = (ANGLE_BITS > 32 || TRIG_FRAC_BITS + 2 > 32) ? 64 : 32,
	localparam int ADDR_W = $clog2(4 * (DATA_W / 8))
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ADDR_W-1:0]            paddr,
	input  logic [DATA_W-1:0]            pwdata,
	output logic [DATA_W-1:0]            prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         func,
	input  logic [ANGLE_BITS-1:0]        in_longitude,
	input  logic signed [ANGLE_BITS-1:0] in_latitude,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ANGLE_BITS-1:0]        out_longitude,
	output logic signed [ANGLE_BITS-1:0] out_latitude
);
	import cpr_pkg::*;

	localparam int ASHIFT = WORD_W - ANGLE_BITS;
	localparam int TWIDTH = TRIG_FRAC_BITS + 2;
	localparam int TSH    = WFRAC - TRIG_FRAC_BITS;
	localparam int TEXT   = WORD_W - TWIDTH - TSH;
	localparam int TOTAL  = 192;

	typedef enum logic [1:0] {
		REG_POLE_LON = 2'd0,
		REG_LON_OFF  = 2'd1,
		REG_POLE_COS = 2'd2,
		REG_POLE_SIN = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic fwd;
		logic flip_lat;
		logic flip_arg;
	} rot_flags_t;

	typedef struct packed {
		logic fwd;
		logic zero_lon;
		logic zero_lat;
	} vec_flags_t;

	// configuration registers
	logic [ANGLE_BITS-1:0] pole_lon_q;
	logic [ANGLE_BITS-1:0] lon_off_q;
	logic [TWIDTH-1:0]     pole_cos_q;
	logic [TWIDTH-1:0]     pole_sin_q;
	reg_idx_t              reg_idx;
	logic                  wr_en;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1 -: 2]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pole_lon_q <= '0;
			lon_off_q  <= '0;
			pole_cos_q <= TWIDTH'(1) << TRIG_FRAC_BITS;
			pole_sin_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_POLE_LON: pole_lon_q <= pwdata[ANGLE_BITS-1:0];
				REG_LON_OFF:  lon_off_q  <= pwdata[ANGLE_BITS-1:0];
				REG_POLE_COS: pole_cos_q <= pwdata[TWIDTH-1:0];
				REG_POLE_SIN: pole_sin_q <= pwdata[TWIDTH-1:0];
				default:      pole_lon_q <= pole_lon_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_POLE_LON: prdata = DATA_W'(pole_lon_q);
			REG_LON_OFF:  prdata = DATA_W'(lon_off_q);
			REG_POLE_COS: prdata = DATA_W'(pole_cos_q);
			REG_POLE_SIN: prdata = DATA_W'(pole_sin_q);
			default:      prdata = '0;
		endcase
	end

	turn_t pl;
	turn_t off;
	word_t cp;
	word_t sp;

	assign pl  = {pole_lon_q, {ASHIFT{1'b0}}};
	assign off = {lon_off_q, {ASHIFT{1'b0}}};
	assign cp  = {{TEXT{pole_cos_q[TWIDTH-1]}}, pole_cos_q, {TSH{1'b0}}};
	assign sp  = {{TEXT{pole_sin_q[TWIDTH-1]}}, pole_sin_q, {TSH{1'b0}}};

	// flow control
	logic [TOTAL-1:0] vld_q;
	logic             out_valid_q;
	logic             out_free;
	logic             adv;

	assign out_free  = !out_valid_q || out_ready;
	assign adv       = out_free || !vld_q[TOTAL-1];
	assign in_ready  = adv;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) vld_q <= {vld_q[TOTAL-2:0], in_valid};
			if (out_free) out_valid_q <= vld_q[TOTAL-1];
		end
	end

	// entry stage: fold angles into the right half plane
	turn_t      lon;
	turn_t      lat;
	turn_t      arg;
	turn_t      lat_sum;
	turn_t      arg_sum;
	turn_t      zlat_s1;
	turn_t      zarg_s1;
	rot_flags_t rf_s1;

	always_comb begin
		lon     = {in_longitude, {ASHIFT{1'b0}}};
		lat     = {in_latitude, {ASHIFT{1'b0}}};
		arg     = lon - (func ? pl : off);
		lat_sum = lat + QUARTER_TURN;
		arg_sum = arg + QUARTER_TURN;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rf_s1.fwd      <= func;
			rf_s1.flip_lat <= lat_sum[WORD_W-1];
			rf_s1.flip_arg <= arg_sum[WORD_W-1];
			zlat_s1        <= lat_sum[WORD_W-1] ? lat + HALF_TURN : lat;
			zarg_s1        <= arg_sum[WORD_W-1] ? arg + HALF_TURN : arg;
		end
	end

	// sine/cosine chains
	word_t lx [STEPS+1];
	word_t ly [STEPS+1];
	turn_t lz [STEPS+1];
	word_t ax [STEPS+1];
	word_t ay [STEPS+1];
	turn_t az [STEPS+1];

	assign lx[0] = INV_GAIN;
	assign ly[0] = '0;
	assign lz[0] = zlat_s1;
	assign ax[0] = INV_GAIN;
	assign ay[0] = '0;
	assign az[0] = zarg_s1;

	for (genvar i = 0; i < STEPS; i++) begin : g_rot
		cpr_cordic_cell #(.STEP(i), .VECTORING(1'b0)) u_lat (
			.clk(clk), .en(adv),
			.x(lx[i]), .y(ly[i]), .z(lz[i]),
			.x_q(lx[i+1]), .y_q(ly[i+1]), .z_q(lz[i+1])
		);
		cpr_cordic_cell #(.STEP(i), .VECTORING(1'b0)) u_arg (
			.clk(clk), .en(adv),
			.x(ax[i]), .y(ay[i]), .z(az[i]),
			.x_q(ax[i+1]), .y_q(ay[i+1]), .z_q(az[i+1])
		);
	end

	rot_flags_t rf_d59;

	cpr_delay #(.W($bits(rot_flags_t)), .DEPTH(STEPS)) u_rf_dly (
		.clk(clk), .en(adv), .d(rf_s1), .q(rf_d59)
	);

	word_t sd_s60;
	word_t cd_s60;
	word_t sa_s60;
	word_t ca_s60;
	logic  fwd_s60;

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s60  <= rf_d59.flip_lat ? -ly[STEPS] : ly[STEPS];
			cd_s60  <= rf_d59.flip_lat ? -lx[STEPS] : lx[STEPS];
			sa_s60  <= rf_d59.flip_arg ? -ay[STEPS] : ay[STEPS];
			ca_s60  <= rf_d59.flip_arg ? -ax[STEPS] : ax[STEPS];
			fwd_s60 <= rf_d59.fwd;
		end
	end

	// product chain
	word_t cdcp_m;
	word_t t1_m;
	word_t sa_d64;
	word_t ca_d64;
	word_t y_m;
	word_t t2_m;
	word_t t1_d68;
	logic  fwd_d68;

	cpr_mul u_mul_cdcp (.clk(clk), .en(adv), .a(cd_s60), .b(cp), .p_q(cdcp_m));
	cpr_mul u_mul_t1   (.clk(clk), .en(adv), .a(sd_s60), .b(sp), .p_q(t1_m));

	cpr_delay #(.W(2 * WORD_W), .DEPTH(4)) u_sc_dly (
		.clk(clk), .en(adv), .d({sa_s60, ca_s60}), .q({sa_d64, ca_d64})
	);

	cpr_mul u_mul_y  (.clk(clk), .en(adv), .a(cdcp_m), .b(sa_d64), .p_q(y_m));
	cpr_mul u_mul_t2 (.clk(clk), .en(adv), .a(cdcp_m), .b(ca_d64), .p_q(t2_m));

	cpr_delay #(.W(WORD_W), .DEPTH(4)) u_t1_dly (
		.clk(clk), .en(adv), .d(t1_m), .q(t1_d68)
	);
	cpr_delay #(.W(1), .DEPTH(8)) u_fwd_dly68 (
		.clk(clk), .en(adv), .d(fwd_s60), .q(fwd_d68)
	);

	word_t s_s69;
	logic  fwd_s69;

	always_ff @(posedge clk) begin
		if (adv) begin
			s_s69   <= fwd_d68 ? t1_d68 + t2_m : t1_d68 - t2_m;
			fwd_s69 <= fwd_d68;
		end
	end

	word_t m3_m;
	word_t sc_s70;
	word_t om_s70;
	word_t op_s70;
	word_t sc;

	cpr_mul u_mul_m3 (.clk(clk), .en(adv), .a(s_s69), .b(sp), .p_q(m3_m));

	always_comb begin
		if (s_s69 > ONE_Q) sc = ONE_Q;
		else if (s_s69 < -ONE_Q) sc = -ONE_Q;
		else sc = s_s69;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sc_s70 <= sc;
			om_s70 <= ONE_Q - sc;
			op_s70 <= ONE_Q + sc;
		end
	end

	word_t u_m;

	cpr_mul u_mul_u (.clk(clk), .en(adv), .a(om_s70), .b(op_s70), .p_q(u_m));

	word_t sd_d73;
	logic  fwd_d73;
	word_t y_d74;

	cpr_delay #(.W(WORD_W), .DEPTH(13)) u_sd_dly (
		.clk(clk), .en(adv), .d(sd_s60), .q(sd_d73)
	);
	cpr_delay #(.W(1), .DEPTH(4)) u_fwd_dly73 (
		.clk(clk), .en(adv), .d(fwd_s69), .q(fwd_d73)
	);
	cpr_delay #(.W(WORD_W), .DEPTH(6)) u_y_dly (
		.clk(clk), .en(adv), .d(y_m), .q(y_d74)
	);

	word_t x_s74;
	logic  fwd_s74;

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s74   <= fwd_d73 ? m3_m - sd_d73 : sd_d73 - m3_m;
			fwd_s74 <= fwd_d73;
		end
	end

	// square root chain
	turn_t qu [STEPS+2];
	turn_t qr [STEPS+2];
	turn_t qt [STEPS+2];

	assign qu[0] = turn_t'(u_m);
	assign qr[0] = '0;
	assign qt[0] = '0;

	for (genvar j = 0; j <= STEPS; j++) begin : g_sqrt
		cpr_sqrt_cell #(.K(STEPS - j)) u_cell (
			.clk(clk), .en(adv),
			.u(qu[j]), .rem(qr[j]), .root(qt[j]),
			.u_q(qu[j+1]), .rem_q(qr[j+1]), .root_q(qt[j+1])
		);
	end

	word_t x_d133;
	word_t y_d133;
	logic  fwd_d133;
	word_t sc_d133;

	cpr_delay #(.W(2 * WORD_W + 1), .DEPTH(STEPS + 1)) u_xy_dly (
		.clk(clk), .en(adv), .d({x_s74, y_d74, fwd_s74}), .q({x_d133, y_d133, fwd_d133})
	);
	cpr_delay #(.W(WORD_W), .DEPTH(63)) u_sc_dly133 (
		.clk(clk), .en(adv), .d(sc_s70), .q(sc_d133)
	);

	// arctangent setup
	word_t      ox_s134;
	word_t      oy_s134;
	turn_t      oz_s134;
	word_t      tx_s134;
	word_t      ty_s134;
	vec_flags_t vf_s134;

	always_ff @(posedge clk) begin
		if (adv) begin
			vf_s134.fwd      <= fwd_d133;
			vf_s134.zero_lon <= (x_d133 == '0) && (y_d133 == '0);
			vf_s134.zero_lat <= (sc_d133 == '0) && (qt[STEPS+1] == '0);
			ox_s134 <= x_d133[WORD_W-1] ? -x_d133 : x_d133;
			oy_s134 <= x_d133[WORD_W-1] ? -y_d133 : y_d133;
			oz_s134 <= x_d133[WORD_W-1] ? HALF_TURN : '0;
			tx_s134 <= word_t'(qt[STEPS+1]);
			ty_s134 <= sc_d133;
		end
	end

	// arctangent chains
	word_t vx [STEPS+1];
	word_t vy [STEPS+1];
	turn_t vz [STEPS+1];
	word_t wx [STEPS+1];
	word_t wy [STEPS+1];
	turn_t wz [STEPS+1];

	assign vx[0] = ox_s134;
	assign vy[0] = oy_s134;
	assign vz[0] = oz_s134;
	assign wx[0] = tx_s134;
	assign wy[0] = ty_s134;
	assign wz[0] = '0;

	for (genvar i = 0; i < STEPS; i++) begin : g_vec
		cpr_cordic_cell #(.STEP(i), .VECTORING(1'b1)) u_lon (
			.clk(clk), .en(adv),
			.x(vx[i]), .y(vy[i]), .z(vz[i]),
			.x_q(vx[i+1]), .y_q(vy[i+1]), .z_q(vz[i+1])
		);
		cpr_cordic_cell #(.STEP(i), .VECTORING(1'b1)) u_lat (
			.clk(clk), .en(adv),
			.x(wx[i]), .y(wy[i]), .z(wz[i]),
			.x_q(wx[i+1]), .y_q(wy[i+1]), .z_q(wz[i+1])
		);
	end

	vec_flags_t vf_d192;

	cpr_delay #(.W($bits(vec_flags_t)), .DEPTH(STEPS)) u_vf_dly (
		.clk(clk), .en(adv), .d(vf_s134), .q(vf_d192)
	);

	// output register
	turn_t lon_sum;
	turn_t lon_rnd;
	turn_t lat_rnd;

	always_comb begin
		lon_sum = (vf_d192.zero_lon ? '0 : vz[STEPS]) + (vf_d192.fwd ? off : pl);
		lon_rnd = lon_sum + (turn_t'(1) << (ASHIFT - 1));
		lat_rnd = (vf_d192.zero_lat ? '0 : wz[STEPS]) + (turn_t'(1) << (ASHIFT - 1));
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_longitude <= lon_rnd[WORD_W-1:ASHIFT];
			out_latitude  <= lat_rnd[WORD_W-1:ASHIFT];
		end
	end

`ifndef ASSERT_OFF
	a_ready_when_tail_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_q[TOTAL-1] |-> in_ready)
		else $error("input blocked with empty pipeline tail");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready && vld_q[TOTAL-1]) |=> $stable(vld_q))
		else $error("pipeline moved while output stalled and tail full");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> vld_q[0])
		else $error("accepted word missing from entry stage");
`endif

endmodule

>>> tb/sv/tb_celestial_pole_rotation_core.sv
// Self-checking testbench for celestial_pole_rotation_core: an integer CORDIC predictor
// scores every output word. Depends on the core RTL and, through it, on cpr_pkg.
module tb_celestial_pole_rotation_core;

	typedef bit [63:0] u64;

	typedef struct packed {
		logic        [31:0] lon;
		logic signed [31:0] lat;
	} coord_t;

	typedef enum logic [3:0] {
		REG_POLE_LON   = 4'h0,
		REG_LON_OFFSET = 4'h4,
		REG_POLE_COS   = 4'h8,
		REG_POLE_SIN   = 4'hC
	} reg_addr_t;

	typedef enum bit {
		DIR_TO_EQUATORIAL = 1'b0,
		DIR_TO_CELESTIAL  = 1'b1
	} direction_t;

	localparam int  STEP_CNT   = 58;
	localparam int  FRAC       = 58;
	localparam u64  HALF       = 64'h8000_0000_0000_0000;
	localparam u64  QUARTER    = 64'h4000_0000_0000_0000;
	localparam longint UNIT    = 64'sd1 <<< FRAC;
	localparam int  CYCLE_LIMIT = 400000;
	localparam int  DRAIN      = 250;

	class coord_board;
		coord_t pending_q[$];
		int     errors;

		function void note(coord_t want);
			pending_q.push_back(want);
		endfunction

		function void check(coord_t got);
			coord_t want;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected word lon=%h lat=%h", $time, got.lon, got.lat);
				errors++;
				return;
			end
			want = pending_q.pop_front();
			if (got.lon !== want.lon) begin
				$display("%0t: out_longitude expected %h actual %h", $time, want.lon, got.lon);
				errors++;
			end
			if (got.lat !== want.lat) begin
				$display("%0t: out_latitude expected %h actual %h", $time, want.lat, got.lat);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [3:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               func = 1'b0;
	logic [31:0]        in_longitude = '0;
	logic signed [31:0] in_latitude = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [31:0]        out_longitude;
	logic signed [31:0] out_latitude;

	celestial_pole_rotation_core dut (.*);

	u64     step_tab[STEP_CNT];
	longint inv_gain;
	logic [31:0] cfg_pole_lon = '0;
	logic [31:0] cfg_lon_offset = '0;
	logic [31:0] cfg_pole_cos = 32'h4000_0000;
	logic [31:0] cfg_pole_sin = '0;
	int     send_idle_pct = 0;
	int     recv_stall_pct = 0;
	int     cycle_cnt = 0;
	coord_board board = new();

	function automatic u64 frac_quot(u64 num, u64 den, int bits);
		u64 q = 0;
		for (int k = 0; k < bits; k++) begin
			num = num << 1;
			q = q << 1;
			if (num >= den) begin
				num = num - den;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic u64 arctan_recip(u64 n);
		u64 p = (64'd1 << 62) / n;
		u64 acc = 0;
		u64 k = 0;
		while (p != 0) begin
			if (k[0]) acc = acc - p / (2 * k + 1);
			else acc = acc + p / (2 * k + 1);
			p = p / (n * n);
			k++;
		end
		return acc;
	endfunction

	function automatic u64 arctan_pow2(int i);
		u64 p = (64'd1 << 62) >> i;
		u64 acc = 0;
		u64 k = 0;
		while (p != 0) begin
			if (k[0]) acc = acc - p / (2 * k + 1);
			else acc = acc + p / (2 * k + 1);
			p = (2 * i < 64) ? (p >> (2 * i)) : 64'd0;
			k++;
		end
		return acc;
	endfunction

	function automatic void rotate(inout longint x, inout longint y, inout u64 z, input bit vect);
		longint dx, dy;
		bit up;
		for (int i = 0; i < STEP_CNT; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			up = vect ? (y < 0) : !z[63];
			if (up) begin
				x -= dx; y += dy; z -= step_tab[i];
			end else begin
				x += dx; y -= dy; z += step_tab[i];
			end
		end
	endfunction

	function automatic void build_tables();
		u64 quarter_arc = 4 * arctan_recip(5) - arctan_recip(239);
		longint x = UNIT;
		longint y = 0;
		u64 z = 0;
		step_tab[0] = 64'd1 << 61;
		for (int i = 1; i < STEP_CNT; i++)
			step_tab[i] = frac_quot(arctan_pow2(i), quarter_arc, 61);
		rotate(x, y, z, 1'b0);
		inv_gain = longint'(frac_quot(u64'(UNIT), u64'(x), FRAC));
	endfunction

	function automatic longint qmul(longint a, longint b);
		bit neg = (a < 0) != (b < 0);
		u64 ua = (a < 0) ? u64'(-a) : u64'(a);
		u64 ub = (b < 0) ? u64'(-b) : u64'(b);
		bit [127:0] p = {64'd0, ua} * {64'd0, ub};
		u64 r = p[121:58] & 64'h7FFF_FFFF_FFFF_FFFF;
		return neg ? -longint'(r) : longint'(r);
	endfunction

	function automatic void sincos(input u64 ang, output longint s, output longint c);
		longint x = inv_gain;
		longint y = 0;
		bit flip = 1'b0;
		if (((ang + QUARTER) & HALF) != 0) begin
			ang += HALF;
			flip = 1'b1;
		end
		rotate(x, y, ang, 1'b0);
		s = flip ? -y : y;
		c = flip ? -x : x;
	endfunction

	function automatic u64 heading(longint y, longint x);
		u64 z = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			x = -x; y = -y; z = HALF;
		end
		rotate(x, y, z, 1'b1);
		return z;
	endfunction

	function automatic longint root_q(u64 u);
		u64 rem = 0;
		u64 root = 0;
		u64 pair, trial;
		for (int k = 58; k >= 0; k--) begin
			pair = (2 * k >= FRAC) ? ((u >> (2 * k - FRAC)) & 3) : 64'd0;
			rem = (rem << 2) | pair;
			trial = (root << 2) | 1;
			if (rem >= trial) begin
				rem -= trial;
				root = (root << 1) | 1;
			end else root = root << 1;
		end
		return longint'(root);
	endfunction

	function automatic u64 arcsin(longint s);
		if (s > UNIT) s = UNIT;
		if (s < -UNIT) s = -UNIT;
		return heading(s, root_q(u64'(qmul(UNIT - s, UNIT + s))));
	endfunction

	function automatic logic [31:0] round_turn(u64 t);
		u64 r = t + (64'd1 << 31);
		return r[63:32];
	endfunction

	function automatic coord_t rotate_coord(bit fwd, logic [31:0] lon_in, logic [31:0] lat_in);
		u64 lon = {lon_in, 32'd0};
		u64 lat = {lat_in, 32'd0};
		u64 pl = {cfg_pole_lon, 32'd0};
		u64 off = {cfg_lon_offset, 32'd0};
		longint cp = longint'($signed(cfg_pole_cos)) <<< 28;
		longint sp = longint'($signed(cfg_pole_sin)) <<< 28;
		longint sd, cd, sa, ca, cdcp, s, x, y;
		u64 lon_out;
		coord_t res;
		sincos(lat, sd, cd);
		cdcp = qmul(cd, cp);
		sincos(lon - (fwd ? pl : off), sa, ca);
		y = qmul(cdcp, sa);
		if (fwd) begin
			s = qmul(sd, sp) + qmul(cdcp, ca);
			x = qmul(s, sp) - sd;
			lon_out = heading(y, x) + off;
		end else begin
			s = qmul(sd, sp) - qmul(cdcp, ca);
			x = sd - qmul(s, sp);
			lon_out = heading(y, x) + pl;
		end
		res.lon = round_turn(lon_out);
		res.lat = round_turn(arcsin(s));
		return res;
	endfunction

	initial forever #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			board.note(rotate_coord(func, in_longitude, in_latitude));
		if (arst_n && out_valid && out_ready)
			board.check('{out_longitude, out_latitude});
	end

	initial forever begin
		@(posedge clk);
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic reg_write(reg_addr_t addr, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (addr)
			REG_POLE_LON:   cfg_pole_lon = val;
			REG_LON_OFFSET: cfg_lon_offset = val;
			REG_POLE_COS:   cfg_pole_cos = val;
			REG_POLE_SIN:   cfg_pole_sin = val;
		endcase
	endtask

	task automatic send_word(direction_t dir, logic [31:0] lon, logic [31:0] lat);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= dir;
		in_longitude <= lon;
		in_latitude <= lat;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain_pipe();
		while (board.pending_q.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic load_pole(logic [31:0] plon, logic [31:0] off, logic [31:0] ang);
		longint s, c;
		sincos({ang, 32'd0}, s, c);
		reg_write(REG_POLE_LON, plon);
		reg_write(REG_LON_OFFSET, off);
		reg_write(REG_POLE_COS, 32'(c >>> 28));
		reg_write(REG_POLE_SIN, 32'(s >>> 28));
	endtask

	initial begin
		logic [31:0] lat_set[5] = '{32'h0, 32'h4000_0000, 32'hC000_0000,
			32'h8000_0000, 32'h7FFF_FFFF};
		logic [31:0] lat;
		build_tables();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int d = 0; d < 2; d++)
			for (int k = 0; k < 5; k++)
				send_word(direction_t'(d), (k % 2) ? 32'hFFFF_FFFF : 32'h1234_5678, lat_set[k]);
		send_word(DIR_TO_CELESTIAL, 32'h0, 32'h2000_0000);
		send_word(DIR_TO_EQUATORIAL, 32'h8000_0000, 32'hE000_0000);
		send_word(DIR_TO_CELESTIAL, 32'h4000_0000, 32'h1000_0000);
		send_word(DIR_TO_EQUATORIAL, 32'hC000_0000, 32'hF000_0000);

		for (int p = 0; p < 5; p++) begin
			in_valid <= 1'b0;
			drain_pipe();
			case (p)
				0: load_pole($urandom, $urandom, $urandom);
				1: begin
					reg_write(REG_POLE_LON, 32'hFFFF_FFFF);
					reg_write(REG_LON_OFFSET, 32'h0);
					reg_write(REG_POLE_COS, 32'h0);
					reg_write(REG_POLE_SIN, 32'h4000_0000);
				end
				2: begin
					reg_write(REG_POLE_LON, 32'h0);
					reg_write(REG_LON_OFFSET, 32'hFFFF_FFFF);
					reg_write(REG_POLE_COS, 32'hC000_0000);
					reg_write(REG_POLE_SIN, 32'hC000_0000);
				end
				default: load_pole($urandom, $urandom, $urandom);
			endcase
			case (p)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
				3: begin send_idle_pct = 24; recv_stall_pct = 24; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			for (int n = 0; n < 128; n++) begin
				case ($urandom_range(9))
					0: lat = $urandom;
					1: lat = $urandom_range(1) ? 32'h4000_0000 : 32'hC000_0000;
					default: lat = $urandom_range(32'h8000_0000) - 32'h4000_0000;
				endcase
				send_word(direction_t'($urandom_range(1)), $urandom, lat);
			end
		end

		in_valid <= 1'b0;
		drain_pipe();
		if (board.errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
